// ===== src/rhd_pkg.sv =====
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared constants, types and codes of the radial heat diffusion line.
// ----------------------------------------------------------------------------
package rhd_pkg;

    localparam int LINE_CELLS = 256;
    localparam int IDX_W      = $clog2(LINE_CELLS);
    localparam int TEMP_W     = 24;
    localparam int RATIO_W    = 16;
    localparam int DIST_W     = 16;
    localparam int CFG_IDX_W  = 2;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic signed [TEMP_W-1:0] t_temp;

    localparam t_idx LAST_CELL = IDX_W'(LINE_CELLS - 1);

    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd16384;

    typedef enum logic [1:0] {
        ACT_RESTART = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_SAMPLE  = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO   = 2'd0,
        CFG_PROBE   = 2'd1,
        CFG_AMBIENT = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_TICK,
        S_SMP_LO,
        S_SMP_HI,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic cnt_clr;
        logic ld_dist;
        logic fill;
        logic rd_tick;
        logic rd_lo;
        logic rd_hi;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_last;
        logic busy;
        logic out_full;
    } t_dp_sts;

endpackage

// ===== src/radial_heat_diffusion_stencil_unit.sv =====
// ----------------------------------------------------------------------------
// radial_heat_diffusion_stencil_unit
// Line of radial temperatures with restart, explicit diffusion tick and
// interpolated sample.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall | i_action, i_distance
//   out     | output    | o_out_valid / i_out_stall | o_temperature
//   cfg     | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// In a tick the one line memory read port walks every cell once, then the
// weighting pipeline drains. A restart makes one write per cell; a sample
// reads two cells.
// Reset clears control state and marks every cell as zero; no clearing pass.
// A waiting output word does not block the input; a new sample holds before
// its first read until the output register is empty.
// ----------------------------------------------------------------------------
module radial_heat_diffusion_stencil_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic [rhd_pkg::DIST_W-1:0]    i_distance,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [rhd_pkg::TEMP_W-1:0] o_temperature,
    input  logic                          i_cfg_we,
    input  logic [rhd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rhd_pkg::TEMP_W-1:0]    i_cfg_data
);

    rhd_pkg::t_dp_cmd cmd;
    rhd_pkg::t_dp_sts sts;

    rhd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_action   (i_action),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rhd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_distance    (i_distance),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_temperature (o_temperature)
    );

endmodule

// ===== src/rhd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rhd_ctrl
// Sequencer: accepts input words and steps the datapath through a restart
// sweep, a tick sweep or a two-read sample.
// ----------------------------------------------------------------------------
module rhd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_action,
    input  rhd_pkg::t_dp_sts      i_sts,
    output rhd_pkg::t_dp_cmd      o_cmd
);

    rhd_pkg::t_state r_state;
    rhd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rhd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rhd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_action)
                        rhd_pkg::ACT_RESTART: n_state = rhd_pkg::S_FILL;
                        rhd_pkg::ACT_TICK:    n_state = rhd_pkg::S_TICK;
                        rhd_pkg::ACT_SAMPLE:  n_state = rhd_pkg::S_SMP_LO;
                        default:              n_state = rhd_pkg::S_IDLE;
                    endcase
                end
            end
            rhd_pkg::S_FILL: begin
                if (i_sts.cnt_last) n_state = rhd_pkg::S_IDLE;
            end
            rhd_pkg::S_TICK: begin
                if (i_sts.cnt_last) n_state = rhd_pkg::S_DRAIN;
            end
            rhd_pkg::S_SMP_LO: begin
                if (!i_sts.out_full) n_state = rhd_pkg::S_SMP_HI;
            end
            rhd_pkg::S_SMP_HI: begin
                n_state = rhd_pkg::S_DRAIN;
            end
            rhd_pkg::S_DRAIN: begin
                if (!i_sts.busy) n_state = rhd_pkg::S_IDLE;
            end
            default: n_state = rhd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            rhd_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    case (i_action)
                        rhd_pkg::ACT_RESTART: o_cmd.cnt_clr = 1'b1;
                        rhd_pkg::ACT_TICK:    o_cmd.cnt_clr = 1'b1;
                        rhd_pkg::ACT_SAMPLE:  o_cmd.ld_dist = 1'b1;
                        default:              o_cmd = '0;
                    endcase
                end
            end
            rhd_pkg::S_FILL:   o_cmd.fill    = 1'b1;
            rhd_pkg::S_TICK:   o_cmd.rd_tick = 1'b1;
            rhd_pkg::S_SMP_LO: o_cmd.rd_lo   = !i_sts.out_full;
            rhd_pkg::S_SMP_HI: o_cmd.rd_hi   = 1'b1;
            rhd_pkg::S_DRAIN:  o_cmd         = '0;
            default:           o_cmd         = '0;
        endcase
    end

endmodule

// ===== src/rhd_datapath.sv =====
// ----------------------------------------------------------------------------
// rhd_datapath
// Line memory, three-cell window, shared two-multiplier weighting pipeline,
// configuration registers and the output word register.
// ----------------------------------------------------------------------------
module rhd_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rhd_pkg::t_dp_cmd              i_cmd,
    output rhd_pkg::t_dp_sts              o_sts,
    input  logic                          i_cfg_we,
    input  logic [rhd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rhd_pkg::TEMP_W-1:0]    i_cfg_data,
    input  logic [rhd_pkg::DIST_W-1:0]    i_distance,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [rhd_pkg::TEMP_W-1:0] o_temperature
);

    localparam int ACC_W = 44;

    // configuration
    logic [rhd_pkg::RATIO_W-1:0] r_ratio;
    rhd_pkg::t_temp              r_probe;
    rhd_pkg::t_temp              r_ambient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio   <= rhd_pkg::RATIO_RESET;
            r_probe   <= '0;
            r_ambient <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rhd_pkg::CFG_RATIO:   r_ratio   <= i_cfg_data[rhd_pkg::RATIO_W-1:0];
                rhd_pkg::CFG_PROBE:   r_probe   <= i_cfg_data;
                rhd_pkg::CFG_AMBIENT: r_ambient <= i_cfg_data;
                default:              r_ratio   <= r_ratio;
            endcase
        end
    end

    // sweep counter and sample distance
    rhd_pkg::t_idx             r_cnt;
    logic [rhd_pkg::DIST_W-1:0] r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.fill || i_cmd.rd_tick) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_dist) r_dist <= i_distance;
    end

    // sample addresses: clamp to the last cell with zero fraction
    logic [31:0]         lo_ext;
    logic                smp_sat;
    rhd_pkg::t_idx       lo_idx;
    rhd_pkg::t_idx       hi_idx;
    logic [7:0]          frac;

    assign lo_ext  = 32'(r_dist[15:8]);
    assign smp_sat = lo_ext >= 32'(rhd_pkg::LINE_CELLS - 1);
    assign lo_idx  = smp_sat ? rhd_pkg::LAST_CELL : rhd_pkg::IDX_W'(lo_ext);
    assign hi_idx  = smp_sat ? rhd_pkg::LAST_CELL : lo_idx + 1'b1;
    assign frac    = smp_sat ? 8'd0 : r_dist[7:0];

    // read port
    logic          rd_en;
    logic          rd_calc;
    rhd_pkg::t_idx raddr;

    assign rd_en   = i_cmd.rd_tick || i_cmd.rd_lo || i_cmd.rd_hi;
    assign rd_calc = i_cmd.rd_tick ? (r_cnt >= rhd_pkg::IDX_W'(2)) : i_cmd.rd_hi;
    assign raddr   = i_cmd.rd_tick ? r_cnt : (i_cmd.rd_lo ? lo_idx : hi_idx);

    // write port
    logic           we;
    rhd_pkg::t_idx  waddr;
    rhd_pkg::t_temp wdata;

    rhd_pkg::t_temp r_mem [rhd_pkg::LINE_CELLS];
    logic [rhd_pkg::LINE_CELLS-1:0] r_valid;
    rhd_pkg::t_temp r_rdata;
    logic           r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (rd_en) r_rdata <= r_mem[raddr];
    end

    // cells never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (we) r_valid[waddr] <= 1'b1;
            if (rd_en) r_rd_ok <= r_valid[raddr];
        end
    end

    logic          r_rd_vld;
    logic          r_rd_calc;
    logic          r_rd_smp;
    rhd_pkg::t_idx r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
        end
        r_rd_calc <= rd_calc;
        r_rd_smp  <= i_cmd.rd_lo || i_cmd.rd_hi;
        r_rd_idx  <= raddr;
    end

    // three-cell window
    rhd_pkg::t_temp rd_val;
    rhd_pkg::t_temp r_left;
    rhd_pkg::t_temp r_centre;
    rhd_pkg::t_temp r_right;
    logic           r_w_vld;
    logic           r_w_smp;
    rhd_pkg::t_idx  r_w_idx;

    assign rd_val = r_rd_ok ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
        end else begin
            r_w_vld <= r_rd_vld && r_rd_calc;
        end
        if (r_rd_vld) begin
            r_left   <= r_centre;
            r_centre <= r_right;
            r_right  <= rd_val;
        end
        r_w_smp <= r_rd_smp;
        r_w_idx <= r_rd_idx - 1'b1;
    end

    // weighting: tick uses lambda*(l+r) + (1-2*lambda)*c,
    // sample uses frac*r + (256-frac)*c
    logic signed [24:0] x1;
    logic signed [16:0] g1;
    logic signed [17:0] g2;
    logic signed [41:0] r_p1;
    logic signed [41:0] r_p2;
    logic               r_m_vld;
    logic               r_m_smp;
    rhd_pkg::t_idx      r_m_idx;

    assign x1 = r_w_smp ? {r_right[23], r_right}
                        : ({r_left[23], r_left} + {r_right[23], r_right});
    assign g1 = r_w_smp ? {9'd0, frac} : {1'b0, r_ratio};
    assign g2 = r_w_smp ? {9'd0, 9'(9'd256 - {1'b0, frac})}
                        : (18'h10000 - {1'b0, r_ratio, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= r_w_vld;
        end
        r_p1    <= g1 * x1;
        r_p2    <= g2 * r_centre;
        r_m_smp <= r_w_smp;
        r_m_idx <= r_w_idx;
    end

    // round half up, floor shift, saturate
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] sh;
    logic                    fits;
    rhd_pkg::t_temp          n_res;
    rhd_pkg::t_temp          r_res;
    logic                    r_s_vld;
    logic                    r_s_smp;
    rhd_pkg::t_idx           r_s_idx;
    logic                    r_copy;

    assign acc  = {{2{r_p1[41]}}, r_p1} + {{2{r_p2[41]}}, r_p2}
                + (r_m_smp ? ACC_W'(128) : ACC_W'(32768));
    assign sh   = r_m_smp ? (acc >>> 8) : (acc >>> 16);
    assign fits = (&sh[ACC_W-1:23]) || !(|sh[ACC_W-1:23]);
    assign n_res = fits ? sh[23:0] : (sh[ACC_W-1] ? 24'h800000 : 24'h7FFFFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_copy  <= 1'b0;
        end else begin
            r_s_vld <= r_m_vld;
            // last cell follows the new value of the cell before it
            r_copy  <= r_s_vld && !r_s_smp && (r_s_idx == rhd_pkg::LAST_CELL - 1'b1);
        end
        r_res   <= n_res;
        r_s_smp <= r_m_smp;
        r_s_idx <= r_m_idx;
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_cnt;
        wdata = r_res;
        priority if (i_cmd.fill) begin
            we    = 1'b1;
            waddr = r_cnt;
            wdata = (r_cnt == '0) ? r_probe : r_ambient;
        end else if (r_s_vld && !r_s_smp) begin
            we    = 1'b1;
            waddr = r_s_idx;
        end else if (r_copy) begin
            we    = 1'b1;
            waddr = rhd_pkg::LAST_CELL;
        end
    end

    // output word register
    logic           r_out_vld;
    rhd_pkg::t_temp r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_s_vld && r_s_smp) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (r_s_vld && r_s_smp) r_out <= r_res;
    end

    assign o_out_valid   = r_out_vld;
    assign o_temperature = r_out;

    assign o_sts.cnt_last = r_cnt == rhd_pkg::LAST_CELL;
    assign o_sts.busy     = r_rd_vld || r_w_vld || r_m_vld || r_s_vld || r_copy;
    assign o_sts.out_full = r_out_vld;

endmodule

// ===== src/rhd_chk.sv =====
// ----------------------------------------------------------------------------
// rhd_chk
// Port-level checks of the diffusion line, bound to the top level.
// ----------------------------------------------------------------------------
module rhd_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [1:0]                    i_action,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [rhd_pkg::TEMP_W-1:0]    o_temperature
);

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_temperature)))
        else $error("stalled output word changed");

    a_sweep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == rhd_pkg::ACT_TICK || i_action == rhd_pkg::ACT_RESTART))
        |=> o_in_stall)
        else $error("line sweep did not hold the input");

    a_unused_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_action == ACT_UNUSED) |=> !o_in_stall)
        else $error("unused action code started work");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_stall)
        else $error("result appeared outside a sample");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset left the block busy");

endmodule

bind radial_heat_diffusion_stencil_unit rhd_chk u_rhd_chk (.*);

// ===== bench/heat_line_checker.sv =====
// ----------------------------------------------------------------------------
// heat_line_checker
// Watches the word channels and the register port of the radial heat line.
// It keeps its own copy of the line, predicts every sample word and
// compares each returned temperature with the oldest prediction.
// ----------------------------------------------------------------------------
module heat_line_checker
    import rhd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [1:0]                i_action,
    input  logic [DIST_W-1:0]         i_distance,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [TEMP_W-1:0]  i_temperature,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [TEMP_W-1:0]         i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TEMP_HI = 64'sd8388607;
    localparam longint TEMP_LO = -64'sd8388608;

    t_temp              line_now [LINE_CELLS];
    logic [RATIO_W-1:0] ratio;
    t_temp              probe;
    t_temp              ambient;
    t_temp              expected_temps [$];
    int                 mismatch_count;

    function automatic t_temp clamp_temp(longint v);
        if (v > TEMP_HI) begin
            return t_temp'(TEMP_HI);
        end
        if (v < TEMP_LO) begin
            return t_temp'(TEMP_LO);
        end
        return t_temp'(v);
    endfunction

    function automatic void restart_line();
        for (int i = 0; i < LINE_CELLS; i++) begin
            line_now[i] = ambient;
        end
        line_now[0] = probe;
    endfunction

    // One explicit step; the centre weight may go negative when lambda > 1/2.
    function automatic void diffuse_line();
        t_temp  fresh [LINE_CELLS];
        longint lam;
        longint cw;
        longint acc;
        lam = longint'(ratio);
        cw  = 65536 - 2 * lam;
        for (int i = 1; i < LINE_CELLS - 1; i++) begin
            acc = lam * (longint'(line_now[i-1]) + longint'(line_now[i+1]))
                + cw * longint'(line_now[i]) + 32768;
            fresh[i] = clamp_temp(acc >>> 16);
        end
        fresh[0]            = line_now[0];
        fresh[LINE_CELLS-1] = fresh[LINE_CELLS-2];
        line_now = fresh;
    endfunction

    function automatic t_temp interpolate_at(logic [DIST_W-1:0] radius);
        int unsigned lo;
        longint      frac;
        longint      acc;
        lo   = radius >> 8;
        frac = radius[7:0];
        // at or past the last cell: hold the last value
        if (lo >= LINE_CELLS - 1) begin
            return line_now[LINE_CELLS-1];
        end
        acc = longint'(line_now[lo]) * (256 - frac)
            + longint'(line_now[lo+1]) * frac + 128;
        return clamp_temp(acc >>> 8);
    endfunction

    always @(posedge i_clk) begin : watch
        t_temp want;
        if (!i_rst_n) begin
            for (int i = 0; i < LINE_CELLS; i++) begin
                line_now[i] = '0;
            end
            ratio   = RATIO_RESET;
            probe   = '0;
            ambient = '0;
            expected_temps.delete();
            mismatch_count = 0;
        end else begin
            // retire the returned word before taking in a new request
            if (i_out_valid && !i_out_stall) begin
                if (expected_temps.size() == 0) begin
                    $error("temperature: no word expected, actual %0d", i_temperature);
                    mismatch_count++;
                end else begin
                    want = expected_temps.pop_front();
                    if (i_temperature !== want) begin
                        $error("temperature: expected %0d, actual %0d", want, i_temperature);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RATIO:   ratio   = i_cfg_data[RATIO_W-1:0];
                    CFG_PROBE:   probe   = i_cfg_data;
                    CFG_AMBIENT: ambient = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_action)
                    ACT_RESTART: restart_line();
                    ACT_TICK:    diffuse_line();
                    ACT_SAMPLE:  expected_temps.push_back(interpolate_at(i_distance));
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_temps.size();
    end

endmodule

// ===== bench/radial_heat_diffusion_stencil_unit_test.sv =====
// ----------------------------------------------------------------------------
// radial_heat_diffusion_stencil_unit_test
// Drives restart, tick and sample words into the radial heat line with
// random gaps and output stalls, reprograms lambda and the boundary
// temperatures between phases, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module radial_heat_diffusion_stencil_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rhd_pkg::*;

    localparam int ITEM_TARGET    = 1750;
    localparam int DRAIN_CYCLES   = LINE_CELLS + 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 800;

    localparam logic [1:0]           ACT_IGNORED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    localparam t_temp              TEMP_TOP    = t_temp'(24'h7FFFFF);
    localparam t_temp              TEMP_BOTTOM = t_temp'(24'h800000);
    localparam logic [RATIO_W-1:0] RATIO_NONE  = 16'h0000;
    localparam logic [RATIO_W-1:0] RATIO_HALF  = 16'h8000;
    localparam logic [RATIO_W-1:0] RATIO_FULL  = 16'hFFFF;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_action    = ACT_RESTART;
    logic [DIST_W-1:0]        i_distance  = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [TEMP_W-1:0] o_temperature;
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = CFG_RATIO;
    logic [TEMP_W-1:0]        i_cfg_data  = '0;

    int fail_count;
    int pending;
    int words_sent;
    bit tx_quiet;
    int rx_hold;
    int rx_run;
    bit rx_level;
    int in_words;
    int idle_cycles;

    radial_heat_diffusion_stencil_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_distance    (i_distance),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_temperature (o_temperature),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    heat_line_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_distance    (i_distance),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_temperature (o_temperature),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit quiet);
        if (quiet) begin
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            return $urandom_range(10, 60);
        end
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
    endfunction

    function automatic t_temp pick_temp();
        case ($urandom_range(0, 5))
            0:       return TEMP_TOP;
            1:       return TEMP_BOTTOM;
            2:       return t_temp'(int'($urandom_range(0, 4095)) - 2048);
            default: return t_temp'($urandom);
        endcase
    endfunction

    function automatic logic [RATIO_W-1:0] pick_ratio();
        case ($urandom_range(0, 7))
            0:       return RATIO_NONE;
            1:       return RATIO_HALF;
            2:       return RATIO_FULL;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // keep most samples near the probe, where ticks actually move the line
    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'($urandom_range(0, 16 * 256 - 1));
            5:             return 16'($urandom_range(16'hFE00, 16'hFFFF));
            default:       return 16'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return ACT_TICK;
        end
        if (r < 85) begin
            return ACT_SAMPLE;
        end
        if (r < 93) begin
            return ACT_RESTART;
        end
        return ACT_IGNORED;
    endfunction

    // Offer one word and hold it until accepted; valid stays high if no gap follows.
    task automatic send_word(logic [1:0] act, logic [DIST_W-1:0] radius);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_distance <= radius;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        if (act != ACT_IGNORED) begin
            words_sent++;
        end
    endtask

    // Drop valid, wait for every sample word, then let a tick or restart finish.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [RATIO_W-1:0] ratio, t_temp probe, t_temp ambient,
                                bit spare);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_RATIO;
        i_cfg_data  <= {8'($urandom), ratio};
        @(posedge i_clk);
        i_cfg_index <= CFG_PROBE;
        i_cfg_data  <= probe;
        @(posedge i_clk);
        i_cfg_index <= CFG_AMBIENT;
        i_cfg_data  <= ambient;
        @(posedge i_clk);
        if (spare) begin
            i_cfg_index <= CFG_SPARE;
            i_cfg_data  <= 24'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: random stall runs, plus two long hold-offs to back up the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_hold  = 0;
            rx_run   = 0;
            rx_level = 1'b0;
            in_words = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                in_words++;
                if (in_words == 300 || in_words == 1200) begin
                    rx_hold = HOLD_CYCLES;
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_stall <= 1'b1;
            end else begin
                if (rx_run == 0) begin
                    rx_level = ($urandom_range(0, 3) == 0);
                    rx_run   = pick_gap(1'b0) + 1;
                end
                rx_run--;
                i_out_stall <= rx_level;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        tx_quiet   = 1'b0;
        words_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // line still all zero after reset, ignored action, tick on a flat line
        send_word(ACT_SAMPLE, 16'h0000);
        send_word(ACT_SAMPLE, 16'hFFFF);
        send_word(ACT_IGNORED, 16'h1234);
        send_word(ACT_TICK, 16'h0000);
        send_word(ACT_SAMPLE, 16'h0180);

        // lambda one half, hottest probe into coldest line
        settle();
        program_regs(RATIO_HALF, TEMP_TOP, TEMP_BOTTOM, 1'b1);
        send_word(ACT_RESTART, 16'h0000);
        send_word(ACT_SAMPLE, 16'h0000);
        send_word(ACT_SAMPLE, 16'h0080);
        send_word(ACT_SAMPLE, 16'h0100);
        send_word(ACT_SAMPLE, 16'hFE80);
        send_word(ACT_SAMPLE, 16'hFF00);
        send_word(ACT_TICK, 16'h0000);
        send_word(ACT_TICK, 16'h0000);
        send_word(ACT_SAMPLE, 16'h0001);
        send_word(ACT_SAMPLE, 16'h00FF);
        send_word(ACT_SAMPLE, 16'h0180);

        // lambda far above one half: unstable, drives the line into saturation
        settle();
        program_regs(RATIO_FULL, TEMP_BOTTOM, TEMP_TOP, 1'b0);
        send_word(ACT_RESTART, 16'h0000);
        send_word(ACT_TICK, 16'h0000);
        send_word(ACT_TICK, 16'h0000);
        send_word(ACT_TICK, 16'h0000);
        send_word(ACT_SAMPLE, 16'h0100);
        send_word(ACT_SAMPLE, 16'h0280);

        // lambda zero: a tick leaves the line as it is
        settle();
        program_regs(RATIO_NONE, t_temp'(24'h000123), t_temp'(-24'sh000456), 1'b0);
        send_word(ACT_RESTART, 16'h0000);
        send_word(ACT_TICK, 16'h0000);
        send_word(ACT_SAMPLE, 16'h0080);

        // random phases: fresh settings, a restart, then a run of mixed words
        while (words_sent < ITEM_TARGET) begin
            settle();
            program_regs(pick_ratio(), pick_temp(), pick_temp(), $urandom_range(0, 3) == 0);
            tx_quiet = ($urandom_range(0, 3) == 0);
            send_word(ACT_RESTART, 16'($urandom));
            n = $urandom_range(30, 110);
            repeat (n) send_word(pick_action(), pick_distance());
        end
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
